// File: rtl/top_k_score_tracker_top_defines.svh
// ----------------------------------------------------------------------------
// Top-k score tracker assertion macros
// Assertion helpers for the tracker RTL; they compile away under SYNTH.
// ----------------------------------------------------------------------------
`ifndef TOP_K_SCORE_TRACKER_TOP_DEFINES_SVH
`define TOP_K_SCORE_TRACKER_TOP_DEFINES_SVH

`ifndef SYNTH
// Check a property on every rising clock edge outside reset.
`define TKST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("top_k_score_tracker assertion failed");
// Check that a condition implies a result in the following cycle.
`define TKST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("top_k_score_tracker sequence assertion failed");
`else
`define TKST_ASSERT(lbl, prop)
`define TKST_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/tkst_pkg.sv
// ----------------------------------------------------------------------------
// Top-k score tracker package
// Shared types, sizes and a helper function for the tracker cells and control.
// ----------------------------------------------------------------------------
package tkst_pkg;

  localparam int CAPACITY = 16;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam int KEEP_W   = 5;
  localparam int SCORE_W  = 8;
  localparam int TAG_W    = 32;
  localparam int RANK_W   = 4;

  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(10);

  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_DUMP  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
    logic               qualifies;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0]  rank;
    logic [SCORE_W-1:0] entry_score;
    logic [TAG_W-1:0]   entry_tag;
    logic               entry_valid;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e mode;
    logic       valid;
    logic       left_ge;
  } cell_ctrl_t;

  // Control from the sequencer to the chain.
  typedef struct packed {
    logic               offer;
    logic               rotate;
    logic               trunc;
    logic [COUNT_W-1:0] keep;
    entry_t             cand;
  } chain_ctrl_t;

  // Status from the chain back to the sequencer.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    entry_t             head;
  } chain_stat_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } tkst_state_e;

  // Zero acts as one, anything above the capacity acts as the capacity.
  function automatic logic [COUNT_W-1:0] eff_keep(input logic [KEEP_W-1:0] k);
    logic [COUNT_W-1:0] r;
    if (k == '0) begin
      r = COUNT_W'(1);
    end else if (int'(k) > CAPACITY) begin
      r = COUNT_W'(CAPACITY);
    end else begin
      r = COUNT_W'(k);
    end
    return r;
  endfunction

endpackage

// File: rtl/tkst_cell.sv
// ----------------------------------------------------------------------------
// Top-k score tracker cell
// One list slot: compares against the candidate and shifts toward its neighbors.
// ----------------------------------------------------------------------------
module tkst_cell import tkst_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     new_i,
  input  entry_t     left_i,
  input  entry_t     right_i,
  output logic       ge_o,
  output entry_t     data_o
);

  entry_t data_q, data_d;

  // Held entries at or above the candidate stay where they are.
  assign ge_o   = ctrl_i.valid && (data_q.score >= new_i.score);
  assign data_o = data_q;

  always_comb begin
    data_d = data_q;
    case (ctrl_i.mode)
      CELL_INSERT: begin
        if (!ge_o) begin
          data_d = ctrl_i.left_ge ? new_i : left_i;
        end
      end
      CELL_ROTATE: begin
        data_d = right_i;
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// File: rtl/tkst_chain.sv
// ----------------------------------------------------------------------------
// Top-k score tracker chain
// Row of list cells with the fill count; inserts offers and rotates for dumps.
// ----------------------------------------------------------------------------
module tkst_chain import tkst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  chain_ctrl_t ctrl_i,
  output chain_stat_t stat_o
);

  logic [COUNT_W-1:0]  count_q, count_d;
  logic [CAPACITY-1:0] ge;
  logic [CAPACITY-1:0] occ;
  entry_t              data [CAPACITY];
  cell_ctrl_t          cctrl [CAPACITY];
  logic                full;
  logic                accept;

  assign full   = (count_q >= ctrl_i.keep);
  // Full and every held entry at or above the candidate: reject.
  assign accept = ctrl_i.offer && !(full && (ge == occ));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left, right;

    assign occ[i] = (COUNT_W'(i) < count_q);

    if (i == 0) begin : g_head
      assign left             = ctrl_i.cand;
      assign cctrl[i].left_ge = 1'b1;
    end else begin : g_body
      assign left             = data[i-1];
      assign cctrl[i].left_ge = ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right = data[0];
    end else begin : g_mid
      // The tail of the occupied run wraps back to the head.
      assign right = (COUNT_W'(i + 1) == count_q) ? data[0] : data[i+1];
    end

    assign cctrl[i].valid = occ[i];
    assign cctrl[i].mode  = accept ? CELL_INSERT :
                            (ctrl_i.rotate && occ[i]) ? CELL_ROTATE : CELL_HOLD;

    tkst_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cctrl[i]),
      .new_i   (ctrl_i.cand),
      .left_i  (left),
      .right_i (right),
      .ge_o    (ge[i]),
      .data_o  (data[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl_i.trunc) begin
      if (count_q > ctrl_i.keep) begin
        count_d = ctrl_i.keep;
      end
    end else if (accept && !full) begin
      count_d = count_q + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign stat_o.count = count_q;
  assign stat_o.head  = data[0];

endmodule

// File: rtl/top_k_score_tracker_top.sv
// ----------------------------------------------------------------------------
// Top-k score tracker
// Keeps the best keep_count (score, tag) pairs in descending score order and
// dumps them on request, one transfer per entry.
// ----------------------------------------------------------------------------
//
//  Port group         Direction  Handshake            Content
//  in_*               in         in_valid_i/in_ready_o   in_item_t (offer or dump)
//  out_*              out        out_valid_o/out_ready_i out_item_t (dump entries)
//  keep_count_*       in         keep_count_we_i         5-bit keep count
//
//  On an offer, every cell compares against the candidate in
//  parallel and the row shifts right below the insertion point on the edge that accepts it.
//  A dump emits max(1, held count) items and can be held by output stalls; the row rotates
//  by one cell per emitted entry, so the list is back in place at the end.
//  in_ready_o is low for the duration of a dump; offers stream back to back.
//  Reset clears the fill count and sets keep_count to 10; cell contents have
//  no reset and are never read beyond the fill count.
//  The output register holds a result under back-pressure; the rotation
//  advances only when that register is free or being drained.
// ----------------------------------------------------------------------------
`include "top_k_score_tracker_top_defines.svh"

module top_k_score_tracker_top import tkst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o,
  input  logic               keep_count_we_i,
  input  logic [KEEP_W-1:0]  keep_count_i
);

  tkst_state_e        state_q, state_d;
  logic [KEEP_W-1:0]  keep_q;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               out_valid_q;
  out_item_t          out_data_q;
  chain_ctrl_t        cctrl;
  chain_stat_t        cstat;
  logic               in_xfer;
  logic               slot_free;
  logic               emit;
  logic               emit_last;
  logic               empty;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign empty     = (cstat.count == '0);
  assign emit_last = empty || ((COUNT_W'(idx_q) + COUNT_W'(1)) == cstat.count);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && (in_data_i.operation == OP_DUMP)) begin
          state_d = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (slot_free && emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready_o = 1'b0;
    emit       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_DUMP: begin
        emit = slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Chain control: a config write truncates at once to the new keep count.
  always_comb begin
    cctrl.offer     = in_xfer && (in_data_i.operation == OP_OFFER) && in_data_i.qualifies;
    cctrl.rotate    = emit && !empty;
    cctrl.trunc     = keep_count_we_i;
    cctrl.keep      = keep_count_we_i ? eff_keep(keep_count_i) : eff_keep(keep_q);
    cctrl.cand      = '{score: in_data_i.score, tag: in_data_i.tag};
  end

  tkst_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cctrl),
    .stat_o (cstat)
  );

  // Dump rank counter: restart on each accepted input item, advance per emitted entry.
  always_comb begin
    idx_d = idx_q;
    if (in_xfer) begin
      idx_d = '0;
    end else if (emit) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      keep_q      <= KEEP_RESET;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (keep_count_we_i) begin
        keep_q <= keep_count_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload; an empty list gives one zero item with entry_valid low, flagged last.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q.rank        <= empty ? '0 : RANK_W'(idx_q);
      out_data_q.entry_score <= empty ? '0 : cstat.head.score;
      out_data_q.entry_tag   <= empty ? '0 : cstat.head.tag;
      out_data_q.entry_valid <= !empty;
      out_data_q.last        <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `TKST_ASSERT(a_count_in_keep, cstat.count <= eff_keep(keep_q))
  `TKST_ASSERT(a_invalid_is_last, !out_valid_o || out_data_o.entry_valid || out_data_o.last)
  `TKST_ASSERT_NEXT(a_dump_blocks_input, in_xfer && (in_data_i.operation == OP_DUMP), !in_ready_o)
  `TKST_ASSERT_NEXT(a_last_frees_input, emit && emit_last, in_ready_o)
  `TKST_ASSERT_NEXT(a_rotate_keeps_count, cctrl.rotate && !keep_count_we_i, $stable(cstat.count))

endmodule
